[hw/rtl/wtsr_pkg.sv]
// ----------------------------------------------------------------------------
// wtsr_pkg
// Shared widths, codes, command type and row saturation for the waveform
// trace span rasterizer.
// ----------------------------------------------------------------------------
package wtsr_pkg;

  localparam int TRACE_POINTS = 281;

  localparam int SAMPLE_W   = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int SCALE_W    = 16;
  localparam int MODE_W     = 2;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = 26;
  localparam int NUM_W      = 28;
  localparam int FULL_W     = NUM_W - 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_COLUMN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q12   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_LEVEL   = 3'd4;

  // register reset values
  localparam logic [MODE_W-1:0]   RST_PASS_MODE   = 2'd1;
  localparam logic [COL_W-1:0]    RST_CENTER_ROW  = 10'd120;
  localparam logic [COL_W-1:0]    RST_LEFT_COLUMN = 10'd20;
  localparam logic [SCALE_W-1:0]  RST_SCALE_Q12   = 16'd1024;
  localparam logic [SAMPLE_W-1:0] RST_MID_LEVEL   = 8'd128;

  localparam logic [MODE_W-1:0] MODE_DOTS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_THIN = 2'd1;

  localparam logic [KIND_W-1:0] KIND_POINT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VSPAN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HSPAN = 2'd2;

  localparam logic [1:0] OP_DOT   = 2'd0;
  localparam logic [1:0] OP_THIN  = 2'd1;
  localparam logic [1:0] OP_THICK = 2'd2;

  localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(TRACE_POINTS - 1);

  localparam logic signed [FULL_W-1:0] ROW_MAX = FULL_W'(2047);
  localparam logic signed [FULL_W-1:0] ROW_MIN = -FULL_W'(2048);

  typedef logic signed [ROW_W-1:0] row_t;
  typedef logic [COL_W-1:0]        col_t;

  typedef struct packed {
    logic [1:0] op;
    col_t       x;
    row_t       v;
    row_t       p;
  } cmd_t;

  function automatic row_t sat_row(input logic signed [FULL_W-1:0] val);
    row_t res;
    if (val > ROW_MAX) begin
      res = row_t'(ROW_MAX);
    end else if (val < ROW_MIN) begin
      res = row_t'(ROW_MIN);
    end else begin
      res = val[ROW_W-1:0];
    end
    return res;
  endfunction

endpackage

[hw/rtl/wtsr_in_if.sv]
// ----------------------------------------------------------------------------
// wtsr_in_if
// Sample channel: one waveform sample per beat.
// ----------------------------------------------------------------------------
interface wtsr_in_if;
  logic                           valid;
  logic                           ready;
  logic [wtsr_pkg::SAMPLE_W-1:0]  sample;
  logic                           first;

  modport source (output valid, output sample, output first, input ready);
  modport sink   (input valid, input sample, input first, output ready);
endinterface

[hw/rtl/wtsr_out_if.sv]
// ----------------------------------------------------------------------------
// wtsr_out_if
// Primitive channel: one point or span per beat.
// ----------------------------------------------------------------------------
interface wtsr_out_if;
  logic                         valid;
  logic                         ready;
  logic [wtsr_pkg::KIND_W-1:0]  kind;
  wtsr_pkg::col_t               col_a;
  wtsr_pkg::col_t               col_b;
  wtsr_pkg::row_t               row_a;
  wtsr_pkg::row_t               row_b;
  logic                         last;

  modport source (output valid, output kind, output col_a, output col_b,
                  output row_a, output row_b, output last, input ready);
  modport sink   (input valid, input kind, input col_a, input col_b,
                  input row_a, input row_b, input last, output ready);
endinterface

[hw/rtl/wtsr_cfg_if.sv]
// ----------------------------------------------------------------------------
// wtsr_cfg_if
// Register write channel: index and data per beat.
// ----------------------------------------------------------------------------
interface wtsr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wtsr_pkg::CFG_IDX_W-1:0]   index;
  logic [wtsr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/waveform_trace_span_rasterizer.sv]
// ----------------------------------------------------------------------------
// waveform_trace_span_rasterizer
// Turns a stream of scope samples into point and span draw primitives.
// ----------------------------------------------------------------------------
// Channels: in_ch takes one sample beat (sample, first); out_ch gives one
// primitive beat (kind, col_a, col_b, row_a, row_b, last), with last set on
// the final primitive of a sample; cfg_ch writes a register by index and is
// always ready. Write registers only while no sample is in flight.
// Path: a sample passes the multiply stage, then the row/classify stage
// into the queue, then the output register, before its first primitive is
// valid on out_ch.
// Throughput: one primitive per cycle leaves the output register while the
// receiver is ready; a sample yields at most one primitive in dots and thin
// modes, up to three in thick mode (two when the row is flat); the front end
// takes a sample every cycle while the four-entry command queue has room.
// Reset: registers return to thin-line mode, center row 120, left column
// 20, scale 0.25, mid level 128; the column and previous row clear, so the
// next line-mode sample only seeds the trace.
// Stall: a stalled receiver holds the output beat, the queue fills, then
// in_ch.ready drops; nothing is dropped.
// ----------------------------------------------------------------------------
module waveform_trace_span_rasterizer (
  input  logic        clk,
  input  logic        rst_n,
  wtsr_in_if.sink     in_ch,
  wtsr_out_if.source  out_ch,
  wtsr_cfg_if.sink    cfg_ch
);

  logic             push_valid;
  logic             push_ready;
  wtsr_pkg::cmd_t   push_cmd;
  logic             head_valid;
  logic             pop;
  wtsr_pkg::cmd_t   head_cmd;

  wtsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .cmd_valid (push_valid),
    .cmd_ready (push_ready),
    .cmd       (push_cmd)
  );

  wtsr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .head_valid (head_valid),
    .pop        (pop),
    .head_cmd   (head_cmd)
  );

  wtsr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

[hw/rtl/wtsr_front.sv]
// ----------------------------------------------------------------------------
// wtsr_front
// Holds the registers, maps each sample to a row through a registered
// multiply, tracks column and previous row, and issues draw commands.
// ----------------------------------------------------------------------------
module wtsr_front (
  input  logic             clk,
  input  logic             rst_n,
  wtsr_in_if.sink          in_ch,
  wtsr_cfg_if.sink         cfg_ch,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output wtsr_pkg::cmd_t   cmd
);

  logic [wtsr_pkg::MODE_W-1:0]   mode_r;
  wtsr_pkg::col_t                center_r;
  wtsr_pkg::col_t                left_r;
  logic [wtsr_pkg::SCALE_W-1:0]  scale_r;
  logic [wtsr_pkg::SAMPLE_W-1:0] mid_r;

  logic                                  s1_valid_r;
  logic                                  s1_first_r;
  logic signed [wtsr_pkg::PROD_W-1:0]    s1_prod_r;

  wtsr_pkg::row_t  prev_row_r;
  wtsr_pkg::col_t  column_r;
  wtsr_pkg::col_t  column_nxt;
  logic            have_prev_r;

  logic signed [wtsr_pkg::SAMPLE_W:0]    diff;
  logic signed [wtsr_pkg::PROD_W-1:0]    prod;
  logic signed [wtsr_pkg::NUM_W-1:0]     num;
  logic signed [wtsr_pkg::FULL_W-1:0]    full;
  wtsr_pkg::row_t                        v;
  wtsr_pkg::col_t                        col_base;
  logic                                  in_span;
  logic                                  emit;
  logic                                  s1_fire;

  function automatic logic signed [wtsr_pkg::PROD_W-1:0] PROD_W_MUL(
    input logic signed [wtsr_pkg::SAMPLE_W:0] a,
    input logic [wtsr_pkg::SCALE_W-1:0]       b
  );
    logic signed [wtsr_pkg::PROD_W-1:0] ae;
    logic signed [wtsr_pkg::PROD_W-1:0] be;
    ae = wtsr_pkg::PROD_W'(a);
    be = $signed({{(wtsr_pkg::PROD_W - wtsr_pkg::SCALE_W){1'b0}}, b});
    return ae * be;
  endfunction

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= wtsr_pkg::RST_PASS_MODE;
      center_r <= wtsr_pkg::RST_CENTER_ROW;
      left_r   <= wtsr_pkg::RST_LEFT_COLUMN;
      scale_r  <= wtsr_pkg::RST_SCALE_Q12;
      mid_r    <= wtsr_pkg::RST_MID_LEVEL;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        wtsr_pkg::CFG_PASS_MODE:   mode_r   <= cfg_ch.data[wtsr_pkg::MODE_W-1:0];
        wtsr_pkg::CFG_CENTER_ROW:  center_r <= cfg_ch.data[wtsr_pkg::COL_W-1:0];
        wtsr_pkg::CFG_LEFT_COLUMN: left_r   <= cfg_ch.data[wtsr_pkg::COL_W-1:0];
        wtsr_pkg::CFG_SCALE_Q12:   scale_r  <= cfg_ch.data[wtsr_pkg::SCALE_W-1:0];
        wtsr_pkg::CFG_MID_LEVEL:   mid_r    <= cfg_ch.data[wtsr_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: signed offset from mid level times scale
  assign diff = $signed({1'b0, in_ch.sample}) - $signed({1'b0, mid_r});
  assign prod = PROD_W_MUL(diff, scale_r);

  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_prod_r  <= prod;
      s1_first_r <= in_ch.first;
    end
  end

  // stage 2: round to a row (floor of value plus one half) and classify
  assign num = $signed({{(wtsr_pkg::NUM_W - wtsr_pkg::COL_W - 12){1'b0}}, center_r, 12'd0})
             + wtsr_pkg::NUM_W'(2048)
             - wtsr_pkg::NUM_W'(s1_prod_r);
  assign full = num[wtsr_pkg::NUM_W-1:12];
  assign v    = wtsr_pkg::sat_row(full);

  assign col_base = s1_first_r ? '0 : column_r;
  assign in_span  = col_base < wtsr_pkg::COL_LIMIT;

  always_comb begin
    cmd.x = left_r + col_base;
    cmd.p = prev_row_r;
    if (mode_r == wtsr_pkg::MODE_DOTS) begin
      emit   = in_span;
      cmd.op = wtsr_pkg::OP_DOT;
      cmd.v  = {{(wtsr_pkg::ROW_W - 8){1'b0}}, full[7:0]};
    end else begin
      emit   = have_prev_r && !s1_first_r && in_span;
      cmd.op = (mode_r == wtsr_pkg::MODE_THIN) ? wtsr_pkg::OP_THIN : wtsr_pkg::OP_THICK;
      cmd.v  = v;
    end
  end

  assign cmd_valid  = s1_valid_r && emit;
  assign s1_fire    = s1_valid_r && (!emit || cmd_ready);
  assign column_nxt = emit ? col_base + 1'b1 : col_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_row_r  <= '0;
      column_r    <= '0;
      have_prev_r <= 1'b0;
    end else if (s1_fire) begin
      prev_row_r  <= v;
      column_r    <= column_nxt;
      have_prev_r <= 1'b1;
    end
  end

endmodule

[hw/rtl/wtsr_queue.sv]
// ----------------------------------------------------------------------------
// wtsr_queue
// Four-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module wtsr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  wtsr_pkg::cmd_t   push_cmd,
  output logic             head_valid,
  input  logic             pop,
  output wtsr_pkg::cmd_t   head_cmd
);

  wtsr_pkg::cmd_t  entry_r [4];
  logic [1:0]      wr_ptr_r;
  logic [1:0]      rd_ptr_r;
  logic [2:0]      count_r;
  logic [2:0]      count_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count_r != 3'd4;
  assign head_valid = count_r != 3'd0;
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 3'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/wtsr_back.sv]
// ----------------------------------------------------------------------------
// wtsr_back
// Expands each command into one to three primitives, one beat per cycle while
// the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module wtsr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  wtsr_pkg::cmd_t   head_cmd,
  output logic             pop,
  wtsr_out_if.source       out_ch
);

  logic [1:0]                   beat_r;
  logic                         out_valid_r;
  logic [wtsr_pkg::KIND_W-1:0]  kind_r;
  wtsr_pkg::col_t               col_a_r;
  wtsr_pkg::col_t               col_b_r;
  wtsr_pkg::row_t               row_a_r;
  wtsr_pkg::row_t               row_b_r;
  logic                         last_r;

  logic [wtsr_pkg::KIND_W-1:0]  kind;
  wtsr_pkg::col_t               col_a;
  wtsr_pkg::col_t               col_b;
  wtsr_pkg::row_t               row_a;
  wtsr_pkg::row_t               row_b;
  logic                         last;
  logic                         load;

  wtsr_pkg::col_t                      xm;
  wtsr_pkg::col_t                      xp;
  logic                                eq;
  logic signed [wtsr_pkg::FULL_W-1:0]  ve;
  logic signed [wtsr_pkg::FULL_W-1:0]  pe;
  logic signed [wtsr_pkg::FULL_W-1:0]  step;
  logic signed [wtsr_pkg::FULL_W-1:0]  lo;
  logic signed [wtsr_pkg::FULL_W-1:0]  hi;

  assign xm   = head_cmd.x - 1'b1;
  assign xp   = head_cmd.x + 1'b1;
  assign ve   = wtsr_pkg::FULL_W'(head_cmd.v);
  assign pe   = wtsr_pkg::FULL_W'(head_cmd.p);
  assign eq   = head_cmd.v == head_cmd.p;
  assign step = (pe > ve) ? ve + 1'b1 : ve - 1'b1;

  // order the span ends so lo is the smaller row
  always_comb begin
    if (pe < step) begin
      lo = pe;
      hi = step;
    end else begin
      lo = step;
      hi = pe;
    end
  end

  always_comb begin
    kind  = wtsr_pkg::KIND_POINT;
    col_a = head_cmd.x;
    col_b = head_cmd.x;
    row_a = head_cmd.v;
    row_b = head_cmd.v;
    last  = 1'b1;
    case (head_cmd.op)
      wtsr_pkg::OP_DOT: ;
      wtsr_pkg::OP_THIN: begin
        if (!eq) begin
          kind  = wtsr_pkg::KIND_VSPAN;
          row_a = head_cmd.p;
          row_b = wtsr_pkg::sat_row(step);
        end
      end
      default: begin
        if (eq) begin
          if (beat_r == 2'd0) begin
            kind  = wtsr_pkg::KIND_HSPAN;
            col_a = xm;
            col_b = xp;
            last  = 1'b0;
          end else begin
            kind  = wtsr_pkg::KIND_VSPAN;
            row_a = wtsr_pkg::sat_row(ve - 1'b1);
            row_b = wtsr_pkg::sat_row(ve + 1'b1);
          end
        end else begin
          kind = wtsr_pkg::KIND_VSPAN;
          case (beat_r)
            2'd0: begin
              col_a = xm;
              col_b = xm;
              row_a = wtsr_pkg::sat_row(lo);
              row_b = wtsr_pkg::sat_row(hi);
              last  = 1'b0;
            end
            2'd1: begin
              col_a = xp;
              col_b = xp;
              row_a = wtsr_pkg::sat_row(lo);
              row_b = wtsr_pkg::sat_row(hi);
              last  = 1'b0;
            end
            default: begin
              row_a = wtsr_pkg::sat_row(hi + 1'b1);
              row_b = wtsr_pkg::sat_row(lo - 1'b1);
            end
          endcase
        end
      end
    endcase
  end

  assign load = head_valid && (!out_valid_r || out_ch.ready);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        beat_r      <= last ? 2'd0 : beat_r + 2'd1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the beat while the receiver stalls
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind;
      col_a_r <= col_a;
      col_b_r <= col_b;
      row_a_r <= row_a;
      row_b_r <= row_b;
      last_r  <= last;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = kind_r;
  assign out_ch.col_a = col_a_r;
  assign out_ch.col_b = col_b_r;
  assign out_ch.row_a = row_a_r;
  assign out_ch.row_b = row_b_r;
  assign out_ch.last  = last_r;

endmodule

[sim/tb_waveform_trace_span_rasterizer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_waveform_trace_span_rasterizer
// Self-checking bench for the waveform trace span rasterizer. It drives scope
// sample traces through the dots, thin-line and thick-line passes under many
// register settings. An in-bench row and span predictor computes the expected
// primitive beats, and every output beat is checked in order. Random idle
// gaps are applied on both sample and output channels, plus a long output stall.
// ----------------------------------------------------------------------------
module tb_waveform_trace_span_rasterizer;
  import wtsr_pkg::*;

  localparam logic [MODE_W-1:0]    MODE_THICK       = OP_THICK;
  localparam logic [MODE_W-1:0]    MODE_THICK_ALT   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;
  localparam int MAX_GAP     = 16;
  localparam int TAIL_CYCLES = 10;

  typedef struct {
    logic [KIND_W-1:0] kind;
    col_t              col_a;
    col_t              col_b;
    row_t              row_a;
    row_t              row_b;
    logic              last;
  } prim_t;

  logic clk = 1'b0;
  logic rst_n;

  wtsr_in_if  in_ch ();
  wtsr_out_if out_ch ();
  wtsr_cfg_if cfg_ch ();

  waveform_trace_span_rasterizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // register copies and trace state of the predictor
  logic [MODE_W-1:0]   pass_mode_q;
  col_t                center_q;
  col_t                left_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [SAMPLE_W-1:0] mid_q;
  row_t                trace_prev_row;
  col_t                trace_column;
  bit                  trace_have_prev;

  prim_t pending_prims[$];

  int src_gap_max;
  int sink_gap_max;
  int sink_hold_cycles;
  int n_samples;
  int n_beats;
  int n_writes;
  int n_errors;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #400_000;
    $display("timeout: results still outstanding, %0d pending", pending_prims.size());
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint row_unclipped(input logic [SAMPLE_W-1:0] s);
    longint num;
    num = longint'(center_q) * 4096 - (longint'(s) - longint'(mid_q)) * longint'(scale_q)
          + 2048;
    return num >>> 12;
  endfunction

  function automatic row_t clip_row(input longint r);
    if (r > 2047) return row_t'(2047);
    if (r < -2048) return row_t'(-2048);
    return row_t'(r);
  endfunction

  function automatic prim_t make_prim(input logic [KIND_W-1:0] kind,
                                      input longint ca, cb, ra, rb, input bit raw);
    prim_t p;
    p.kind  = kind;
    p.col_a = col_t'(ca);
    p.col_b = col_t'(cb);
    if (raw) begin
      // dots keep the low byte of the unclipped row
      p.row_a = row_t'({4'b0, ra[7:0]});
      p.row_b = row_t'({4'b0, rb[7:0]});
    end else begin
      p.row_a = clip_row(ra);
      p.row_b = clip_row(rb);
    end
    p.last = 1'b0;
    return p;
  endfunction

  function automatic void predict_primitives(input logic [SAMPLE_W-1:0] s, input logic f);
    longint full, x, near_v, span_lo, span_hi, t;
    row_t   v, p;
    bit     joined;
    prim_t  batch[$];
    full   = row_unclipped(s);
    v      = clip_row(full);
    p      = trace_prev_row;
    joined = trace_have_prev && !f;
    if (f) trace_column = '0;
    x      = longint'(left_q) + longint'(trace_column);
    near_v = (p > v) ? longint'(v) + 1 : longint'(v) - 1;
    if (pass_mode_q == MODE_DOTS) begin
      if (trace_column < COL_LIMIT) begin
        batch.push_back(make_prim(KIND_POINT, x, x, full, full, 1'b1));
        trace_column++;
      end
    end else if (joined && trace_column < COL_LIMIT) begin
      if (pass_mode_q == MODE_THIN) begin
        if (v == p) batch.push_back(make_prim(KIND_POINT, x, x, p, p, 1'b0));
        else        batch.push_back(make_prim(KIND_VSPAN, x, x, p, near_v, 1'b0));
      end else if (v == p) begin
        batch.push_back(make_prim(KIND_HSPAN, x - 1, x + 1, v, v, 1'b0));
        batch.push_back(make_prim(KIND_VSPAN, x, x, longint'(v) - 1, longint'(v) + 1, 1'b0));
      end else begin
        span_lo = near_v;
        span_hi = longint'(p);
        if (span_hi < span_lo) begin
          t       = span_hi;
          span_hi = span_lo;
          span_lo = t;
        end
        batch.push_back(make_prim(KIND_VSPAN, x - 1, x - 1, span_lo, span_hi, 1'b0));
        batch.push_back(make_prim(KIND_VSPAN, x + 1, x + 1, span_lo, span_hi, 1'b0));
        batch.push_back(make_prim(KIND_VSPAN, x, x, span_hi + 1, span_lo - 1, 1'b0));
      end
      trace_column++;
    end
    trace_prev_row  = v;
    trace_have_prev = 1'b1;
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) pending_prims.push_back(batch[i]);
  endfunction

  // ----------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    if (n_errors <= 40) begin
      $display("mismatch on beat %0d: %s got %0d expected %0d", n_beats, what, got, want);
    end
  endtask

  always @(posedge clk) begin : check_beats
    prim_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      n_beats++;
      if (pending_prims.size() == 0) begin
        report_mismatch("beat with nothing pending, kind", out_ch.kind, -1);
      end else begin
        want = pending_prims.pop_front();
        if (out_ch.kind !== want.kind)   report_mismatch("kind", out_ch.kind, want.kind);
        if (out_ch.col_a !== want.col_a) report_mismatch("col_a", out_ch.col_a, want.col_a);
        if (out_ch.col_b !== want.col_b) report_mismatch("col_b", out_ch.col_b, want.col_b);
        if (out_ch.row_a !== want.row_a) report_mismatch("row_a", out_ch.row_a, want.row_a);
        if (out_ch.row_b !== want.row_b) report_mismatch("row_b", out_ch.row_b, want.row_b);
        if (out_ch.last !== want.last)   report_mismatch("last", out_ch.last, want.last);
      end
    end
  end

  // result receiver: random ready gaps, plus a long hold-off on request
  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        gap              = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, sink_gap_max);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  // ------------------------------------------------------------------ driving

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic f);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.first  <= f;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_primitives(s, f);
    n_samples++;
  endtask

  // hold off the sender until every pending primitive is out, then let the
  // pipeline settle since a seeding sample leaves no beat behind
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_prims.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      CFG_PASS_MODE:   pass_mode_q = data[MODE_W-1:0];
      CFG_CENTER_ROW:  center_q    = data[COL_W-1:0];
      CFG_LEFT_COLUMN: left_q      = data[COL_W-1:0];
      CFG_SCALE_Q12:   scale_q     = data[SCALE_W-1:0];
      CFG_MID_LEVEL:   mid_q       = data[SAMPLE_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [MODE_W-1:0] mode, input col_t center,
                               input col_t left, input logic [SCALE_W-1:0] scale,
                               input logic [SAMPLE_W-1:0] mid);
    drain_results();
    write_reg(CFG_PASS_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_CENTER_ROW, CFG_DATA_W'(center));
    write_reg(CFG_LEFT_COLUMN, CFG_DATA_W'(left));
    write_reg(CFG_SCALE_Q12, scale);
    write_reg(CFG_MID_LEVEL, CFG_DATA_W'(mid));
  endtask

  task automatic randomize_setting();
    logic [15:0]         noise;
    logic [MODE_W-1:0]   mode;
    col_t                center;
    col_t                left;
    logic [SCALE_W-1:0]  scale;
    logic [SAMPLE_W-1:0] mid;
    noise = 16'($urandom);
    mode  = MODE_W'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       center = '0;
      1:       center = '1;
      default: center = col_t'($urandom_range(0, 1023));
    endcase
    case ($urandom_range(0, 3))
      0:       left = '0;
      1:       left = '1;
      default: left = col_t'($urandom_range(0, 1023));
    endcase
    case ($urandom_range(0, 5))
      0:       scale = '0;
      1:       scale = '1;
      2:       scale = 16'($urandom);
      default: scale = 16'($urandom_range(0, 8192));
    endcase
    case ($urandom_range(0, 3))
      0:       mid = '0;
      1:       mid = '1;
      default: mid = 8'($urandom);
    endcase
    // upper data bits beyond each register width must be dropped
    drain_results();
    write_reg(CFG_PASS_MODE, {noise[15:2], mode});
    write_reg(CFG_CENTER_ROW, {noise[15:10], center});
    write_reg(CFG_LEFT_COLUMN, {noise[9:4], left});
    write_reg(CFG_SCALE_Q12, scale);
    write_reg(CFG_MID_LEVEL, {noise[7:0], mid});
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 2)), 16'($urandom));
    end
  endtask

  // -------------------------------------------------------------------- tests

  // reset values; a sample without first right after reset only seeds
  task automatic test_reset_values();
    send_sample(8'd200, 1'b0);
    send_sample(8'd128, 1'b0);
    send_sample(8'd128, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
  endtask

  task automatic test_dots_rows();
    apply_setting(MODE_DOTS, 10'd1023, 10'd1000, 16'hFFFF, 8'd0);
    send_sample(8'd0, 1'b1);
    send_sample(8'd255, 1'b0);
    // half-row scale: rounding of negative half rows, column wraps past 1023
    apply_setting(MODE_DOTS, 10'd0, 10'd1023, 16'd2048, 8'd0);
    send_sample(8'd1, 1'b1);
    send_sample(8'd3, 1'b0);
    send_sample(8'd255, 1'b0);
  endtask

  task automatic test_thin_joins();
    apply_setting(MODE_THIN, 10'd1023, 10'd0, 16'hFFFF, 8'd255);
    send_sample(8'd0, 1'b1);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd128, 1'b0);
    send_sample(8'd100, 1'b1);
    send_sample(8'd100, 1'b0);
  endtask

  task automatic test_thick_pass();
    apply_setting(MODE_THICK, 10'd500, 10'd0, 16'd4096, 8'd128);
    send_sample(8'd128, 1'b1);
    send_sample(8'd128, 1'b0);
    send_sample(8'd120, 1'b0);
    send_sample(8'd140, 1'b0);
    // clipped at the bottom of the row range, in the mode-3 alias
    apply_setting(MODE_THICK_ALT, 10'd0, 10'd1023, 16'hFFFF, 8'd0);
    send_sample(8'd255, 1'b1);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b0);
    // clipped at the top
    apply_setting(MODE_THICK, 10'd1023, 10'd512, 16'hFFFF, 8'd255);
    send_sample(8'd0, 1'b1);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b0);
  endtask

  // previous row survives every mode change
  task automatic test_mode_switch();
    apply_setting(MODE_THIN, 10'd300, 10'd100, 16'd4096, 8'd128);
    send_sample(8'd128, 1'b1);
    send_sample(8'd130, 1'b0);
    drain_results();
    write_reg(CFG_PASS_MODE, CFG_DATA_W'(MODE_THICK));
    send_sample(8'd126, 1'b0);
    drain_results();
    write_reg(CFG_PASS_MODE, CFG_DATA_W'(MODE_DOTS));
    send_sample(8'd128, 1'b0);
    drain_results();
    write_reg(CFG_PASS_MODE, CFG_DATA_W'(MODE_THIN));
    send_sample(8'd140, 1'b0);
  endtask

  // stall the receiver long enough for the queue to fill and block input
  task automatic test_output_stall();
    apply_setting(MODE_THICK, 10'd200, 10'd40, 16'd6000, 8'd128);
    src_gap_max      = 0;
    sink_hold_cycles = 150;
    send_sample(8'd128, 1'b1);
    repeat (24) send_sample(8'($urandom), 1'b0);
    // sender waits for the block to empty, then the trace goes on
    drain_results();
    src_gap_max = MAX_GAP;
    repeat (8) send_sample(8'($urandom), 1'b0);
  endtask

  task automatic test_random_traces();
    int sent;
    int run_len;
    int level;
    logic f;
    logic [SAMPLE_W-1:0] s;
    sent = 0;
    while (sent < 110) begin
      randomize_setting();
      src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      repeat ($urandom_range(2, 4)) begin
        run_len = $urandom_range(1, 12);
        level   = $urandom_range(0, 255);
        for (int i = 0; i < run_len; i++) begin
          case ($urandom_range(0, 9))
            0:       s = '0;
            1:       s = '1;
            2, 3:    s = 8'($urandom);
            default: begin
              level = level + int'($urandom_range(0, 16)) - 8;
              if (level < 0) level = 0;
              if (level > 255) level = 255;
              s = 8'(level);
            end
          endcase
          // mostly well-formed traces, with a dropped or stray first now and then
          f = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0);
          send_sample(s, f);
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------- main

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    in_ch.first   = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    pass_mode_q     = RST_PASS_MODE;
    center_q        = RST_CENTER_ROW;
    left_q          = RST_LEFT_COLUMN;
    scale_q         = RST_SCALE_Q12;
    mid_q           = RST_MID_LEVEL;
    trace_prev_row  = '0;
    trace_column    = '0;
    trace_have_prev = 1'b0;
    src_gap_max      = MAX_GAP;
    sink_gap_max     = MAX_GAP;
    sink_hold_cycles = 0;
    n_samples = 0;
    n_beats   = 0;
    n_writes  = 0;
    n_errors  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_dots_rows();
    test_thin_joins();
    test_thick_pass();
    test_mode_switch();
    test_output_stall();
    test_random_traces();
    drain_results();

    $display("covered %0d samples, %0d primitive beats, %0d register writes, %0d mismatches",
             n_samples, n_beats, n_writes, n_errors);
    $display("dots, thin and thick passes with row clipping, column wrap, mode changes, stalls");
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/wtsr_pkg.sv
hw/rtl/wtsr_in_if.sv
hw/rtl/wtsr_out_if.sv
hw/rtl/wtsr_cfg_if.sv
hw/rtl/wtsr_front.sv
hw/rtl/wtsr_queue.sv
hw/rtl/wtsr_back.sv
hw/rtl/waveform_trace_span_rasterizer.sv
sim/tb_waveform_trace_span_rasterizer.sv
